/* rtl/bwbs_pkg.sv */
// ----------------------------------------------------------------------------
// bwbs_pkg
// Shared types, codes and helpers of the wake-burst sequencer.
// ----------------------------------------------------------------------------
package bwbs_pkg;

   localparam int unsigned DELAY_W = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned OP_W    = 16;

   localparam logic [OP_W-1:0] OP_NONE    = 16'h0000;
   localparam logic [OP_W-1:0] OP_ADDRESS = 16'hfc01;
   localparam logic [OP_W-1:0] OP_PARAMS  = 16'h2006;
   localparam logic [OP_W-1:0] OP_DATA    = 16'h2008;
   localparam logic [OP_W-1:0] OP_ENABLE  = 16'h200a;

   localparam logic [7:0] MIN_EVENT_LENGTH = 8'd6;

   localparam logic [1:0]  SETUP_NONE  = 2'd0;
   localparam logic [1:0]  SETUP_VALID = 2'd1;

   localparam logic [15:0] RESET_TIMEOUT_MS = 16'd1000;
   localparam logic [15:0] RESET_BURST_MS   = 16'd2000;
   localparam logic [15:0] RESET_RETRY_MS   = 16'd5;

   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

   typedef enum logic [1:0] {
      REG_SETUP_STATE = 2'd0,
      REG_TIMEOUT     = 2'd1,
      REG_BURST_LEN   = 2'd2,
      REG_RETRY       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_REQUEST = 2'd1,
      MODE_EVENT   = 2'd2,
      MODE_INIT    = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      PH_DISABLED    = 4'd0,
      PH_IDLE        = 4'd1,
      PH_ADDRESS     = 4'd2,
      PH_PARAMS      = 4'd3,
      PH_DATA        = 4'd4,
      PH_ENABLE      = 4'd5,
      PH_ADVERTISING = 4'd6,
      PH_DISABLE     = 4'd7,
      PH_RESTORE     = 4'd8,
      PH_FAILED      = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      KIND_ADDRESS = 3'd0,
      KIND_PARAMS  = 3'd1,
      KIND_DATA    = 3'd2,
      KIND_ENABLE  = 3'd3,
      KIND_DISABLE = 3'd4,
      KIND_RESTORE = 3'd5
   } kind_type;

   typedef struct packed {
      logic [1:0]  setup_state;
      logic [15:0] command_timeout_ms;
      logic [15:0] burst_length_ms;
      logic [15:0] retry_interval_ms;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic [TIME_W-1:0] now_ms;
      logic              link_ready;
      logic              send_ok;
      logic [7:0]        event_length;
      logic [OP_W-1:0]   event_opcode;
      logic [7:0]        event_status;
   } req_type;

   typedef struct packed {
      phase_type          phase;
      logic [OP_W-1:0]    pending_opcode;
      logic [TIME_W-1:0]  command_deadline;
      logic [TIME_W-1:0]  burst_deadline;
      logic               address_changed;
      logic               advertising_on;
      logic               initialized;
      logic [COUNT_W-1:0] requests_total;
      logic [COUNT_W-1:0] bursts_total;
      logic [COUNT_W-1:0] failures_total;
   } state_type;

   typedef struct packed {
      logic               cmd_valid;
      logic [2:0]         cmd_kind;
      logic [OP_W-1:0]    cmd_opcode;
      logic               request_accepted;
      logic [3:0]         phase_code;
      logic               busy_res;
      logic [COUNT_W-1:0] accepted_count;
      logic [COUNT_W-1:0] burst_count;
      logic [COUNT_W-1:0] failure_count;
      logic               delay_valid;
      logic [DELAY_W-1:0] next_delay_ms;
   } rsp_type;

   // Deadline reached when (now - deadline) is non-negative modulo 2^32.
   function automatic logic reached(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] deadline);
      logic [TIME_W-1:0] diff;
      diff = now - deadline;
      return ~diff[TIME_W-1];
   endfunction

   function automatic logic [DELAY_W-1:0] left_until(input logic [TIME_W-1:0] now,
                                                     input logic [TIME_W-1:0] deadline);
      logic [TIME_W-1:0]  diff;
      logic [DELAY_W-1:0] res;
      diff = deadline - now;
      if (reached(now, deadline)) begin
         res = '0;
      end else if (|diff[TIME_W-1:DELAY_W]) begin
         res = DELAY_MAX;
      end else begin
         res = diff[DELAY_W-1:0];
      end
      return res;
   endfunction

   function automatic logic needs_work(input phase_type ph);
      return (ph != PH_DISABLED) && (ph != PH_IDLE) && (ph != PH_FAILED);
   endfunction

   // Phase to fall back to after a failure.
   function automatic phase_type unwind_phase(input logic adv_on, input logic addr_chg);
      phase_type ph;
      if (adv_on) begin
         ph = PH_DISABLE;
      end else if (addr_chg) begin
         ph = PH_RESTORE;
      end else begin
         ph = PH_IDLE;
      end
      return ph;
   endfunction

endpackage

/* rtl/bwbs_csr.sv */
// ----------------------------------------------------------------------------
// bwbs_csr
// Configuration register file, written one word per handshake.
// ----------------------------------------------------------------------------
module bwbs_csr
   import bwbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SETUP_STATE: cfg_in.setup_state        = csr_wdata[1:0];
            REG_TIMEOUT:     cfg_in.command_timeout_ms = csr_wdata;
            REG_BURST_LEN:   cfg_in.burst_length_ms    = csr_wdata;
            REG_RETRY:       cfg_in.retry_interval_ms  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_state        <= SETUP_NONE;
         cfg_ff.command_timeout_ms <= RESET_TIMEOUT_MS;
         cfg_ff.burst_length_ms    <= RESET_BURST_MS;
         cfg_ff.retry_interval_ms  <= RESET_RETRY_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bwbs_step.sv */
// ----------------------------------------------------------------------------
// bwbs_step
// Next-state and result logic for one word: tick, request, event or init.
// ----------------------------------------------------------------------------
module bwbs_step
   import bwbs_pkg::*;
(
   input  state_type cur,
   input  cfg_type   cfg,
   input  req_type   req,
   output state_type nxt,
   output rsp_type   rsp
);

   state_type        st;
   logic [1:0]       fail_inc;
   logic             req_inc;
   logic             burst_inc;
   logic             accepted;
   logic             issue;
   kind_type         kind;
   logic [OP_W-1:0]  op;

   always_comb begin
      st        = cur;
      fail_inc  = 2'd0;
      req_inc   = 1'b0;
      burst_inc = 1'b0;
      accepted  = 1'b0;
      issue     = 1'b0;
      kind      = KIND_ADDRESS;
      op        = OP_NONE;

      case (req.mode)
         MODE_TICK: begin
            // Command timeout first, then burst expiry, then try a send.
            if ((st.pending_opcode != OP_NONE) && reached(req.now_ms, st.command_deadline)) begin
               fail_inc         = fail_inc + 2'd1;
               st.pending_opcode = OP_NONE;
               st.phase          = unwind_phase(st.advertising_on, st.address_changed);
            end
            if ((st.phase == PH_ADVERTISING) && reached(req.now_ms, st.burst_deadline)) begin
               st.phase = PH_DISABLE;
            end
            if ((st.pending_opcode == OP_NONE) && req.link_ready) begin
               issue = 1'b1;
               case (st.phase)
                  PH_ADDRESS: begin kind = KIND_ADDRESS; op = OP_ADDRESS; end
                  PH_PARAMS:  begin kind = KIND_PARAMS;  op = OP_PARAMS;  end
                  PH_DATA:    begin kind = KIND_DATA;    op = OP_DATA;    end
                  PH_ENABLE:  begin kind = KIND_ENABLE;  op = OP_ENABLE;  end
                  PH_DISABLE: begin kind = KIND_DISABLE; op = OP_ENABLE;  end
                  PH_RESTORE: begin kind = KIND_RESTORE; op = OP_ADDRESS; end
                  default:    issue = 1'b0;
               endcase
            end
            if (issue) begin
               st.pending_opcode   = op;
               st.command_deadline = req.now_ms + TIME_W'(cfg.command_timeout_ms);
               if (!req.send_ok) begin
                  fail_inc          = fail_inc + 2'd1;
                  st.pending_opcode = OP_NONE;
                  st.phase          = unwind_phase(st.advertising_on, st.address_changed);
               end
            end
         end
         MODE_REQUEST: begin
            if (st.phase == PH_IDLE) begin
               req_inc  = 1'b1;
               st.phase = PH_ADDRESS;
               accepted = 1'b1;
            end
         end
         MODE_EVENT: begin
            if ((req.event_length >= MIN_EVENT_LENGTH) && (st.pending_opcode != OP_NONE)
                && (req.event_opcode == st.pending_opcode)) begin
               st.pending_opcode = OP_NONE;
               if (req.event_status != 8'd0) begin
                  fail_inc = 2'd1;
                  st.phase = unwind_phase(st.advertising_on, st.address_changed);
               end else begin
                  case (st.phase)
                     PH_ADDRESS: begin
                        st.address_changed = 1'b1;
                        st.phase           = PH_PARAMS;
                     end
                     PH_PARAMS: st.phase = PH_DATA;
                     PH_DATA:   st.phase = PH_ENABLE;
                     PH_ENABLE: begin
                        st.advertising_on = 1'b1;
                        st.burst_deadline = req.now_ms + TIME_W'(cfg.burst_length_ms);
                        st.phase          = PH_ADVERTISING;
                     end
                     PH_DISABLE: begin
                        st.advertising_on = 1'b0;
                        st.phase          = PH_RESTORE;
                     end
                     PH_RESTORE: begin
                        st.address_changed = 1'b0;
                        burst_inc          = 1'b1;
                        st.phase           = PH_IDLE;
                     end
                     default: begin
                        fail_inc = 2'd1;
                        st.phase = unwind_phase(st.advertising_on, st.address_changed);
                     end
                  endcase
               end
            end
         end
         MODE_INIT: begin
            if (!st.initialized) begin
               st.initialized = 1'b1;
               if (cfg.setup_state == SETUP_VALID) begin
                  st.phase = PH_IDLE;
               end else if (cfg.setup_state != SETUP_NONE) begin
                  st.phase = PH_FAILED;
                  fail_inc = 2'd1;
               end
            end
         end
         default: st = cur;
      endcase

      st.failures_total = cur.failures_total + COUNT_W'(fail_inc);
      st.requests_total = cur.requests_total + COUNT_W'(req_inc);
      st.bursts_total   = cur.bursts_total + COUNT_W'(burst_inc);
   end

   assign nxt = st;

   always_comb begin
      rsp                  = '0;
      rsp.cmd_valid        = issue;
      rsp.cmd_kind         = issue ? kind : 3'd0;
      rsp.cmd_opcode       = op;
      rsp.request_accepted = accepted;
      rsp.phase_code       = st.phase;
      rsp.busy_res         = needs_work(st.phase);
      rsp.accepted_count   = st.requests_total;
      rsp.burst_count      = st.bursts_total;
      rsp.failure_count    = st.failures_total;
      rsp.delay_valid      = 1'b1;
      if (accepted) begin
         rsp.next_delay_ms = '0;
      end else if (st.pending_opcode != OP_NONE) begin
         rsp.next_delay_ms = left_until(req.now_ms, st.command_deadline);
      end else if (st.phase == PH_ADVERTISING) begin
         rsp.next_delay_ms = left_until(req.now_ms, st.burst_deadline);
      end else if (needs_work(st.phase)) begin
         rsp.next_delay_ms = cfg.retry_interval_ms;
      end else begin
         rsp.delay_valid   = 1'b0;
         rsp.next_delay_ms = '0;
      end
   end

endmodule

/* rtl/ble_wake_burst_sequencer_core.sv */
// ----------------------------------------------------------------------------
// ble_wake_burst_sequencer_core
// Steps a radio controller through one advertising burst with timeouts.
// ----------------------------------------------------------------------------
// A word accepted on req_ waits in the input register, then moves to the
// result register, which offers it on rsp_. One word per cycle while rsp_ready
//    allows; the two registers form a two-stage pipeline, and sequencer state
//    updates as a word moves into the second, so each word sees its predecessor.
// Reset: synchronous, active high; clears phase (disabled), pending command,
//    deadlines, flags, totals and both pipeline valids; config returns to
//    1000 / 2000 / 5 ms with setup not configured.
module ble_wake_burst_sequencer_core
   import bwbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input words
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic                req_link_ready,
   input  logic                req_send_ok,
   input  logic [7:0]          req_event_length,
   input  logic [OP_W-1:0]     req_event_opcode,
   input  logic [7:0]          req_event_status,
   // result words
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_cmd_valid,
   output logic [2:0]          rsp_cmd_kind,
   output logic [OP_W-1:0]     rsp_cmd_opcode,
   output logic                rsp_request_accepted,
   output logic [3:0]          rsp_phase_code,
   output logic                rsp_busy_res,
   output logic [COUNT_W-1:0]  rsp_accepted_count,
   output logic [COUNT_W-1:0]  rsp_burst_count,
   output logic [COUNT_W-1:0]  rsp_failure_count,
   output logic                rsp_delay_valid,
   output logic [DELAY_W-1:0]  rsp_next_delay_ms,
   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   cfg_type   cfg;
   req_type   req_ff;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   bwbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the held word into the result register when that slot is free
   // or being drained this cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;

   // Input register: hold the payload until it advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.mode         <= mode_type'(req_mode);
         req_ff.now_ms       <= req_now_ms;
         req_ff.link_ready   <= req_link_ready;
         req_ff.send_ok      <= req_send_ok;
         req_ff.event_length <= req_event_length;
         req_ff.event_opcode <= req_event_opcode;
         req_ff.event_status <= req_event_status;
      end
   end

   bwbs_step u_step (
      .cur (state_ff),
      .cfg (cfg),
      .req (req_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Sequencer state: commit only when the word is handed to the result side.
   // All-zero is the disabled phase with nothing pending.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cmd_valid        = rsp_ff.cmd_valid;
   assign rsp_cmd_kind         = rsp_ff.cmd_kind;
   assign rsp_cmd_opcode       = rsp_ff.cmd_opcode;
   assign rsp_request_accepted = rsp_ff.request_accepted;
   assign rsp_phase_code       = rsp_ff.phase_code;
   assign rsp_busy_res         = rsp_ff.busy_res;
   assign rsp_accepted_count   = rsp_ff.accepted_count;
   assign rsp_burst_count      = rsp_ff.burst_count;
   assign rsp_failure_count    = rsp_ff.failure_count;
   assign rsp_delay_valid      = rsp_ff.delay_valid;
   assign rsp_next_delay_ms    = rsp_ff.next_delay_ms;

   // A single word unwinds at most twice: timeout, then a failed resend.
   a_fail_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> ((state_ff.failures_total - $past(state_ff.failures_total))
                         <= COUNT_W'(2)))
      else $error("failure total jumped by more than two");

   // The request total moves only together with an accepted-request result.
   a_req_count: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && (state_ff.requests_total != $past(state_ff.requests_total)))
      |-> (rsp_valid_ff && rsp_ff.request_accepted))
      else $error("request total changed without an accepted request");

   // An accepted request always lands in the address phase with zero delay.
   a_accept_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.request_accepted) |->
      ((rsp_ff.phase_code == PH_ADDRESS) && rsp_ff.delay_valid
       && (rsp_ff.next_delay_ms == '0) && !rsp_ff.cmd_valid))
      else $error("accepted request result malformed");

endmodule

/* tb/ble_wake_burst_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// ble_wake_burst_sequencer_core_tb
// Self-checking bench for the wake-burst sequencer. A ledger class predicts
// every result word from the accepted input words and the register settings,
// and checks the results in order. Directed bursts and failure paths come
// first, then random sequences under several register settings, with
// bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ble_wake_burst_sequencer_core_tb
   import bwbs_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 110;
   localparam int PHASE_COUNT  = 5;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   // Receiver stall styles.
   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_CADENCE,
      RX_SPARSE
   } rx_style_type;

   // -------------------------------------------------------------------------
   // Ledger: predicts the sequencer and checks result words in order.
   // -------------------------------------------------------------------------
   class burst_ledger;
      logic [1:0]   setup_sel;
      logic [15:0]  timeout_ms;
      logic [15:0]  burst_ms;
      logic [15:0]  retry_ms;

      phase_type    phase;
      logic [15:0]  pend_op;
      logic [31:0]  cmd_deadline;
      logic [31:0]  burst_deadline;
      bit           addr_changed;
      bit           adv_on;
      bit           init_done;
      logic [31:0]  requests_n;
      logic [31:0]  bursts_n;
      logic [31:0]  failures_n;

      rsp_type      due_results[$];
      int           mismatches;
      int           results_seen;

      function new();
         setup_sel      = SETUP_NONE;
         timeout_ms     = RESET_TIMEOUT_MS;
         burst_ms       = RESET_BURST_MS;
         retry_ms       = RESET_RETRY_MS;
         phase          = PH_DISABLED;
         pend_op        = OP_NONE;
         cmd_deadline   = '0;
         burst_deadline = '0;
         addr_changed   = 1'b0;
         adv_on         = 1'b0;
         init_done      = 1'b0;
         requests_n     = '0;
         bursts_n       = '0;
         failures_n     = '0;
         mismatches     = 0;
         results_seen   = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [15:0] data);
         case (idx)
            REG_SETUP_STATE: setup_sel  = data[1:0];
            REG_TIMEOUT:     timeout_ms = data;
            REG_BURST_LEN:   burst_ms   = data;
            REG_RETRY:       retry_ms   = data;
            default:         ;
         endcase
      endfunction

      // Compare modulo 2^32: reached once now is not behind the deadline.
      function bit deadline_hit(logic [31:0] now, logic [31:0] deadline);
         logic [31:0] lag;
         lag = now - deadline;
         return !lag[31];
      endfunction

      function logic [15:0] time_left(logic [31:0] now, logic [31:0] deadline);
         logic [31:0] gap;
         gap = deadline - now;
         if (deadline_hit(now, deadline))
            return 16'd0;
         return (gap > 32'd65535) ? 16'hffff : gap[15:0];
      endfunction

      function bit in_sequence();
         return phase != PH_DISABLED && phase != PH_IDLE && phase != PH_FAILED;
      endfunction

      // Count a failure and back out of whatever was set up so far.
      function void fall_back();
         failures_n++;
         pend_op = OP_NONE;
         if (adv_on)
            phase = PH_DISABLE;
         else if (addr_changed)
            phase = PH_RESTORE;
         else
            phase = PH_IDLE;
      endfunction

      function void take_word(req_type w);
         rsp_type     r;
         logic [15:0] op;
         kind_type    kind;
         bit          issue;
         r     = '0;
         op    = OP_NONE;
         kind  = KIND_ADDRESS;
         issue = 1'b1;
         case (w.mode)
            MODE_TICK: begin
               if (pend_op != OP_NONE && deadline_hit(w.now_ms, cmd_deadline))
                  fall_back();
               if (phase == PH_ADVERTISING && deadline_hit(w.now_ms, burst_deadline))
                  phase = PH_DISABLE;
               case (phase)
                  PH_ADDRESS: begin kind = KIND_ADDRESS; op = OP_ADDRESS; end
                  PH_PARAMS:  begin kind = KIND_PARAMS;  op = OP_PARAMS;  end
                  PH_DATA:    begin kind = KIND_DATA;    op = OP_DATA;    end
                  PH_ENABLE:  begin kind = KIND_ENABLE;  op = OP_ENABLE;  end
                  PH_DISABLE: begin kind = KIND_DISABLE; op = OP_ENABLE;  end
                  PH_RESTORE: begin kind = KIND_RESTORE; op = OP_ADDRESS; end
                  default:    issue = 1'b0;
               endcase
               if (issue && pend_op == OP_NONE && w.link_ready) begin
                  pend_op      = op;
                  cmd_deadline = w.now_ms + {16'h0000, timeout_ms};
                  r.cmd_valid  = 1'b1;
                  r.cmd_kind   = kind;
                  r.cmd_opcode = op;
                  if (!w.send_ok)
                     fall_back();
               end
            end
            MODE_REQUEST: begin
               if (phase == PH_IDLE) begin
                  requests_n++;
                  phase = PH_ADDRESS;
                  r.request_accepted = 1'b1;
               end
            end
            MODE_EVENT: begin
               if (w.event_length >= MIN_EVENT_LENGTH && pend_op != OP_NONE &&
                   w.event_opcode == pend_op) begin
                  pend_op = OP_NONE;
                  if (w.event_status != 8'd0) begin
                     fall_back();
                  end else begin
                     case (phase)
                        PH_ADDRESS: begin addr_changed = 1'b1; phase = PH_PARAMS; end
                        PH_PARAMS:  phase = PH_DATA;
                        PH_DATA:    phase = PH_ENABLE;
                        PH_ENABLE: begin
                           adv_on         = 1'b1;
                           burst_deadline = w.now_ms + {16'h0000, burst_ms};
                           phase          = PH_ADVERTISING;
                        end
                        PH_DISABLE: begin adv_on = 1'b0; phase = PH_RESTORE; end
                        PH_RESTORE: begin
                           addr_changed = 1'b0;
                           bursts_n++;
                           phase = PH_IDLE;
                        end
                        default: fall_back();
                     endcase
                  end
               end
            end
            MODE_INIT: begin
               if (!init_done) begin
                  init_done = 1'b1;
                  if (setup_sel == SETUP_VALID) begin
                     phase = PH_IDLE;
                  end else if (setup_sel != SETUP_NONE) begin
                     phase = PH_FAILED;
                     failures_n++;
                  end
               end
            end
            default: ;
         endcase

         r.phase_code     = phase;
         r.busy_res       = in_sequence();
         r.accepted_count = requests_n;
         r.burst_count    = bursts_n;
         r.failure_count  = failures_n;
         if (r.request_accepted) begin
            r.delay_valid = 1'b1;
         end else if (pend_op != OP_NONE) begin
            r.delay_valid   = 1'b1;
            r.next_delay_ms = time_left(w.now_ms, cmd_deadline);
         end else if (phase == PH_ADVERTISING) begin
            r.delay_valid   = 1'b1;
            r.next_delay_ms = time_left(w.now_ms, burst_deadline);
         end else if (in_sequence()) begin
            r.delay_valid   = 1'b1;
            r.next_delay_ms = retry_ms;
         end
         due_results.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d: %s expected %h got %h", results_seen, field, want, got);
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d: unexpected word, nothing outstanding", results_seen);
         end else begin
            want = due_results.pop_front();
            compare("cmd_valid",        want.cmd_valid,        got.cmd_valid);
            compare("cmd_kind",         want.cmd_kind,         got.cmd_kind);
            compare("cmd_opcode",       want.cmd_opcode,       got.cmd_opcode);
            compare("request_accepted", want.request_accepted, got.request_accepted);
            compare("phase_code",       want.phase_code,       got.phase_code);
            compare("busy_res",         want.busy_res,         got.busy_res);
            compare("accepted_count",   want.accepted_count,   got.accepted_count);
            compare("burst_count",      want.burst_count,      got.burst_count);
            compare("failure_count",    want.failure_count,    got.failure_count);
            compare("delay_valid",      want.delay_valid,      got.delay_valid);
            compare("next_delay_ms",    want.next_delay_ms,    got.next_delay_ms);
         end
         results_seen++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode         = '0;
   logic [TIME_W-1:0]  req_now_ms       = '0;
   logic               req_link_ready   = 1'b0;
   logic               req_send_ok      = 1'b0;
   logic [7:0]         req_event_length = '0;
   logic [OP_W-1:0]    req_event_opcode = '0;
   logic [7:0]         req_event_status = '0;

   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic               rsp_cmd_valid;
   logic [2:0]         rsp_cmd_kind;
   logic [OP_W-1:0]    rsp_cmd_opcode;
   logic               rsp_request_accepted;
   logic [3:0]         rsp_phase_code;
   logic               rsp_busy_res;
   logic [COUNT_W-1:0] rsp_accepted_count;
   logic [COUNT_W-1:0] rsp_burst_count;
   logic [COUNT_W-1:0] rsp_failure_count;
   logic               rsp_delay_valid;
   logic [DELAY_W-1:0] rsp_next_delay_ms;

   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index        = '0;
   logic [15:0]        csr_wdata        = '0;

   burst_ledger        ledger = new();
   logic [31:0]        wall_ms;          // running millisecond time of the stimulus
   bit                 hold_ask = 1'b0;  // ask the receiver for one long hold-off
   int                 cycle_count = 0;

   // Register settings per random phase: defaults, the low extremes, the
   // high extremes, zero timeout and burst length, then random values filled in at run time.
   logic [15:0]        setup_set   [PHASE_COUNT] = '{16'd1, 16'd0, 16'd2, 16'hffff, 16'd1};
   logic [15:0]        timeout_set [PHASE_COUNT] = '{16'd1000, 16'd1, 16'hffff, 16'd0, 16'd0};
   logic [15:0]        burst_set   [PHASE_COUNT] = '{16'd2000, 16'd1, 16'hffff, 16'd0, 16'd0};
   logic [15:0]        retry_set   [PHASE_COUNT] = '{16'd5, 16'd0, 16'hffff, 16'd7, 16'd0};

   ble_wake_burst_sequencer_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_now_ms           (req_now_ms),
      .req_link_ready       (req_link_ready),
      .req_send_ok          (req_send_ok),
      .req_event_length     (req_event_length),
      .req_event_opcode     (req_event_opcode),
      .req_event_status     (req_event_status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_cmd_valid        (rsp_cmd_valid),
      .rsp_cmd_kind         (rsp_cmd_kind),
      .rsp_cmd_opcode       (rsp_cmd_opcode),
      .rsp_request_accepted (rsp_request_accepted),
      .rsp_phase_code       (rsp_phase_code),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_accepted_count   (rsp_accepted_count),
      .rsp_burst_count      (rsp_burst_count),
      .rsp_failure_count    (rsp_failure_count),
      .rsp_delay_valid      (rsp_delay_valid),
      .rsp_next_delay_ms    (rsp_next_delay_ms),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Drivers. Every task starts and ends on a rising edge.
   // -------------------------------------------------------------------------

   // Offer one word and hold it until the block takes it; leave valid high so
   // a back-to-back word follows without a bubble.
   task automatic send_word(input req_type w);
      req_valid        <= 1'b1;
      req_mode         <= w.mode;
      req_now_ms       <= w.now_ms;
      req_link_ready   <= w.link_ready;
      req_send_ok      <= w.send_ok;
      req_event_length <= w.event_length;
      req_event_opcode <= w.event_opcode;
      req_event_status <= w.event_status;
      do @(posedge clock); while (req_ready !== 1'b1);
      ledger.take_word(w);
   endtask

   task automatic send_fields(input mode_type m, input logic [31:0] now,
                              input bit rdy, input bit ok, input logic [7:0] len,
                              input logic [15:0] op, input logic [7:0] st);
      req_type w;
      w.mode         = m;
      w.now_ms       = now;
      w.link_ready   = rdy;
      w.send_ok      = ok;
      w.event_length = len;
      w.event_opcode = op;
      w.event_status = st;
      send_word(w);
   endtask

   // Drop valid for the requested idle gap; an empty gap keeps the burst going.
   task automatic idle_for(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Write one register; lower valid only after the last write of a series.
   task automatic write_reg(input reg_index_type idx, input logic [15:0] data,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (last)
         csr_valid <= 1'b0;
      ledger.set_reg(idx, data);
   endtask

   // Hold input off until every expected result is back, then let the
   // two-stage pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (ledger.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Build the next random word. Most words follow the sequence the ledger
   // is in, with random timing, busy links, failed sends and bad status;
   // the rest are noise with random fields, mostly at the running time.
   function automatic req_type pick_word();
      req_type w;
      int      roll;
      w.mode         = mode_type'($urandom_range(0, 3));
      w.now_ms       = $urandom;
      w.link_ready   = 1'($urandom_range(0, 1));
      w.send_ok      = 1'($urandom_range(0, 1));
      w.event_length = 8'($urandom_range(0, 255));
      w.event_opcode = 16'($urandom_range(0, 65535));
      w.event_status = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      wall_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(4, 60) : $urandom_range(0, 3);
      if (roll < 10) begin
         // noise, mostly at the running time; a wild time hits saturation
         if (roll < 7)
            w.now_ms = wall_ms;
         return w;
      end
      w.now_ms       = wall_ms;
      w.link_ready   = 1'b1;
      w.send_ok      = 1'b1;
      w.event_length = 8'($urandom_range(MIN_EVENT_LENGTH, 255));
      w.event_status = 8'd0;
      if (ledger.pend_op != OP_NONE) begin
         w.event_opcode = ledger.pend_op;
         if (roll < 78) begin
            // answer the command, now and then with a bad status
            w.mode = MODE_EVENT;
            if ($urandom_range(0, 19) == 0)
               w.event_status = 8'($urandom_range(1, 255));
         end else if (roll < 88) begin
            // tick right around the command deadline
            w.mode   = MODE_TICK;
            w.now_ms = ledger.cmd_deadline - 1 + $urandom_range(0, 2);
         end else begin
            // short event or one for another command
            w.mode = MODE_EVENT;
            if (roll < 94)
               w.event_length = 8'($urandom_range(0, MIN_EVENT_LENGTH - 1));
            else
               w.event_opcode = ledger.pend_op ^ (16'h0001 << $urandom_range(0, 15));
         end
      end else if (ledger.phase == PH_IDLE) begin
         w.mode = (roll < 85) ? MODE_REQUEST : MODE_TICK;
      end else if (ledger.phase == PH_ADVERTISING) begin
         w.mode = MODE_TICK;
         if (roll < 60)
            w.now_ms = ledger.burst_deadline - 1 + $urandom_range(0, 3);
      end else begin
         w.mode       = MODE_TICK;
         w.link_ready = ($urandom_range(0, 9) != 0);
         w.send_ok    = ($urandom_range(0, 19) != 0);
      end
      wall_ms = w.now_ms;
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: stall on a changing pattern; on request, hold off for a long
   // stretch so the pipeline fills and the input stalls.
   // -------------------------------------------------------------------------
   initial begin : receiver
      rx_style_type style;
      int           style_left;
      int           hold_left;
      int           beat;
      style      = RX_OPEN;
      style_left = 0;
      hold_left  = 0;
      beat       = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = rx_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(16, 96);
            end
            style_left--;
            beat++;
            case (style)
               RX_OPEN:    rsp_ready <= 1'b1;
               RX_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_CADENCE: rsp_ready <= (beat % 5 < 3);
               default:    rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Check every result word the receiver takes.
   always @(posedge clock) begin : result_monitor
      rsp_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.cmd_valid        = rsp_cmd_valid;
         got.cmd_kind         = rsp_cmd_kind;
         got.cmd_opcode       = rsp_cmd_opcode;
         got.request_accepted = rsp_request_accepted;
         got.phase_code       = rsp_phase_code;
         got.busy_res         = rsp_busy_res;
         got.accepted_count   = rsp_accepted_count;
         got.burst_count      = rsp_burst_count;
         got.failure_count    = rsp_failure_count;
         got.delay_valid      = rsp_delay_valid;
         got.next_delay_ms    = rsp_next_delay_ms;
         ledger.check_word(got);
      end
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ble_wake_burst_sequencer_core_tb: done, errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] t;
      int          burst_left;
      bit          gaps_on;
      timeout_set[4] = 16'($urandom_range(1, 65535));
      burst_set[4]   = 16'($urandom_range(1, 65535));
      retry_set[4]   = 16'($urandom_range(0, 65535));
      burst_left     = 0;

      // Hold reset, then release it for good.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Mark the wake packet valid; the time registers keep their reset values.
      write_reg(REG_SETUP_STATE, {14'd0, SETUP_VALID}, 1'b1);

      // Before initialize: tick, request and event all leave it disabled.
      send_fields(MODE_TICK,    32'h0000_0000, 1'b1, 1'b1, 8'hff, 16'hffff, 8'hff);
      send_fields(MODE_REQUEST, 32'hffff_ffff, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   32'h1234_5678, 1'b0, 1'b0, 8'hff, OP_ADDRESS, 8'h00);
      // Initialize once to idle; a repeat is ignored.
      send_fields(MODE_INIT,    32'h0000_0001, 1'b0, 1'b0, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_INIT,    32'h0000_0002, 1'b0, 1'b0, 8'h00, OP_NONE, 8'h00);

      // One clean burst, timed just below the wrap of the millisecond clock.
      t = 32'hffff_fc00;
      send_fields(MODE_REQUEST, t,     1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_REQUEST, t,     1'b1, 1'b1, 8'h00, OP_NONE, 8'h00); // refused
      send_fields(MODE_TICK,    t + 1, 1'b0, 1'b1, 8'h00, OP_NONE, 8'h00); // link busy
      send_fields(MODE_TICK,    t + 2, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   t + 3, 1'b1, 1'b1, MIN_EVENT_LENGTH - 8'd1, OP_ADDRESS,
                  8'h00);
      send_fields(MODE_EVENT,   t + 3, 1'b1, 1'b1, MIN_EVENT_LENGTH, OP_PARAMS, 8'h00);
      send_fields(MODE_EVENT,   t + 4, 1'b1, 1'b1, MIN_EVENT_LENGTH, OP_ADDRESS, 8'h00);
      send_fields(MODE_TICK,    t + 5, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   t + 6, 1'b1, 1'b1, 8'd14, OP_PARAMS, 8'h00);
      send_fields(MODE_TICK,    t + 7, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   t + 8, 1'b1, 1'b1, 8'd6, OP_DATA, 8'h00);
      send_fields(MODE_TICK,    t + 9, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   t + 10, 1'b1, 1'b1, 8'd6, OP_ENABLE, 8'h00);
      // Advertising until the burst deadline, past the wrap; disable on time.
      send_fields(MODE_TICK,    t + 2009, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_TICK,    t + 2010, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   t + 2011, 1'b1, 1'b1, 8'd6, OP_ENABLE, 8'h00);
      send_fields(MODE_TICK,    t + 2012, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_EVENT,   t + 2013, 1'b1, 1'b1, 8'd6, OP_ADDRESS, 8'h00);

      // Failed send: the command shows as issued and unwinds to idle.
      t = t + 2100;
      send_fields(MODE_REQUEST, t,     1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_TICK,    t + 1, 1'b1, 1'b0, 8'h00, OP_NONE, 8'h00);
      // Command timeout: one short of the deadline, then on it.
      send_fields(MODE_REQUEST, t + 2, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_TICK,    t + 3, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_TICK,    t + 1002, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      send_fields(MODE_TICK,    t + 1003, 1'b1, 1'b1, 8'h00, OP_NONE, 8'h00);
      drain_results();

      // Random phases, each under its own register settings.
      wall_ms = $urandom;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_reg(REG_SETUP_STATE, setup_set[p],   1'b0);
         write_reg(REG_TIMEOUT,     timeout_set[p], 1'b0);
         write_reg(REG_BURST_LEN,   burst_set[p],   1'b0);
         write_reg(REG_RETRY,       retry_set[p],   1'b1);
         // one phase runs without any sender gaps
         gaps_on = (p != 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // long receiver hold-off while the sender keeps offering
            if (p == 2 && n == 20)
               hold_ask = 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if (gaps_on)
                  idle_for($urandom_range(0, 6));
            end
            burst_left--;
            send_word(pick_word());
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.due_results.size() == 0) begin
         $display("ble_wake_burst_sequencer_core_tb: done, clean");
      end else begin
         $display("ble_wake_burst_sequencer_core_tb: done, errors");
      end
      $finish;
   end

endmodule
